[hw/rtl/awsf_pkg.sv]
// awsf_pkg: shared types, opcodes and helpers for the alu with status flags
// used by awsf_exec, awsf_flags and alu_with_status_flags; no dependencies
package awsf_pkg;

  localparam int unsigned DATA_W  = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CNT_W   = 5;
  localparam logic [DATA_W-1:0] MASK16 = 16'hFFFF;
  localparam logic [DATA_W-1:0] MASK8  = 16'h00FF;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_AND = 4'd2,
    OP_OR  = 4'd3,
    OP_XOR = 4'd4,
    OP_NEG = 4'd5,
    OP_SHL = 4'd6,
    OP_SHR = 4'd7,
    OP_SAR = 4'd8
  } op_t;

  // operands after input register
  typedef struct packed {
    logic [3:0]        op;
    logic              bytem;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [CNT_W-1:0]  cnt;
  } opnd_t;

  // alu core output
  typedef struct packed {
    logic [DATA_W-1:0] res;
    logic              cf;
    logic              of;
    logic              ok;
    logic              bytem;
  } exec_t;

  typedef struct packed {
    logic zf;
    logic sf;
    logic pf;
  } flags_t;

  function automatic logic msb_of(input logic [DATA_W-1:0] v, input logic bytem);
    msb_of = bytem ? v[BYTE_W-1] : v[DATA_W-1];
  endfunction

endpackage

[hw/rtl/awsf_exec.sv]
// awsf_exec: add, subtract, logic, negate and shift core with carry and overflow
// depends on awsf_pkg
module awsf_exec (
  input  awsf_pkg::opnd_t opnd,
  output awsf_pkg::exec_t ex
);

  logic [awsf_pkg::DATA_W-1:0] mask;
  logic [awsf_pkg::DATA_W:0]   sum;
  logic [awsf_pkg::DATA_W-1:0] diff;
  logic [awsf_pkg::CNT_W-1:0]  cnt_m1;
  logic [31:0]                 shl_w;
  logic [31:0]                 shl_p;
  logic [31:0]                 ext;
  logic [31:0]                 sar_w;
  logic [31:0]                 sar_p;
  logic [awsf_pkg::DATA_W-1:0] shr_r;
  logic [awsf_pkg::DATA_W-1:0] shr_p;
  logic                        sa;
  logic                        sb;
  logic                        sr;
  logic                        cnz;

  always_comb begin
    mask   = opnd.bytem ? awsf_pkg::MASK8 : awsf_pkg::MASK16;
    sa     = awsf_pkg::msb_of(opnd.a, opnd.bytem);
    sb     = awsf_pkg::msb_of(opnd.b, opnd.bytem);
    sum    = {1'b0, opnd.a} + {1'b0, opnd.b};
    diff   = (opnd.a - opnd.b) & mask;
    cnt_m1 = opnd.cnt - 5'd1;
    cnz    = (opnd.cnt != '0);
    shl_w  = {16'h0000, opnd.a} << opnd.cnt;
    shl_p  = {16'h0000, opnd.a} << cnt_m1;
    shr_r  = opnd.a >> opnd.cnt;
    shr_p  = opnd.a >> cnt_m1;
    ext    = sa ? {16'hFFFF, opnd.a | ~mask} : {16'h0000, opnd.a};
    sar_w  = $unsigned($signed(ext) >>> opnd.cnt);
    sar_p  = $unsigned($signed(ext) >>> cnt_m1);

    ex.res   = '0;
    ex.cf    = 1'b0;
    ex.of    = 1'b0;
    ex.ok    = 1'b1;
    ex.bytem = opnd.bytem;
    sr       = 1'b0;

    unique case (opnd.op)
      awsf_pkg::OP_ADD: begin
        ex.res = sum[awsf_pkg::DATA_W-1:0] & mask;
        ex.cf  = opnd.bytem ? sum[awsf_pkg::BYTE_W] : sum[awsf_pkg::DATA_W];
        sr     = awsf_pkg::msb_of(ex.res, opnd.bytem);
        ex.of  = (sa == sb) && (sr != sa);
      end
      awsf_pkg::OP_SUB: begin
        ex.res = diff;
        ex.cf  = (opnd.a < opnd.b);
        sr     = awsf_pkg::msb_of(diff, opnd.bytem);
        ex.of  = (sa != sb) && (sr != sa);
      end
      awsf_pkg::OP_AND: ex.res = opnd.a & opnd.b;
      awsf_pkg::OP_OR:  ex.res = opnd.a | opnd.b;
      awsf_pkg::OP_XOR: ex.res = opnd.a ^ opnd.b;
      awsf_pkg::OP_NEG: begin
        ex.res = (16'h0000 - opnd.a) & mask;
        ex.cf  = (opnd.a != '0);
      end
      awsf_pkg::OP_SHL: begin
        ex.res = shl_w[awsf_pkg::DATA_W-1:0] & mask;
        ex.cf  = cnz & awsf_pkg::msb_of(shl_p[awsf_pkg::DATA_W-1:0], opnd.bytem);
        ex.of  = awsf_pkg::msb_of(ex.res, opnd.bytem) != ex.cf;
      end
      awsf_pkg::OP_SHR: begin
        ex.res = shr_r & mask;
        ex.cf  = cnz & shr_p[0];
        ex.of  = awsf_pkg::msb_of(ex.res, opnd.bytem);
      end
      awsf_pkg::OP_SAR: begin
        ex.res = sar_w[awsf_pkg::DATA_W-1:0] & mask;
        ex.cf  = cnz & sar_p[0];
        ex.of  = awsf_pkg::msb_of(ex.res, opnd.bytem);
      end
      default: ex.ok = 1'b0;
    endcase
  end

endmodule

[hw/rtl/awsf_flags.sv]
// awsf_flags: zero, sign and parity flags from a registered alu result
// depends on awsf_pkg
module awsf_flags (
  input  awsf_pkg::exec_t  ex,
  output awsf_pkg::flags_t fl
);

  always_comb begin
    fl.zf = ex.ok & (ex.res == '0);
    fl.sf = ex.ok & awsf_pkg::msb_of(ex.res, ex.bytem);
    fl.pf = ex.ok & ~(^ex.res[awsf_pkg::BYTE_W-1:0]);
  end

endmodule

[hw/rtl/alu_with_status_flags.sv]
// alu_with_status_flags: three-stage pipelined alu with 8086-style flags
// depends on awsf_pkg, awsf_exec and awsf_flags
//
// One request enters per cycle while req_ready is high: stage one registers the
// masked operands, stage two holds the adder and barrel shifter output with carry
// and overflow, stage three holds the result with zero, sign and parity.
// The result register waits for rsp_ready while later requests keep moving into
// empty stages; req_ready falls only when all three stages hold a request.
module alu_with_status_flags (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [3:0]  opcode,
  input  logic        byte_mode,
  input  logic [15:0] operand_a,
  input  logic [15:0] operand_b,
  input  logic [4:0]  shift_count,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [15:0] result,
  output logic        carry_flag,
  output logic        overflow_flag,
  output logic        zero_flag,
  output logic        sign_flag,
  output logic        parity_flag
);

  logic             v1;
  logic             v2;
  logic             v3;
  logic             adv1;
  logic             adv2;
  logic             adv3;
  awsf_pkg::opnd_t  s1;
  awsf_pkg::exec_t  s2;
  awsf_pkg::exec_t  ex_next;
  awsf_pkg::flags_t fl_next;
  logic             bytem3;

  assign adv3      = !v3 || rsp_ready;
  assign adv2      = !v2 || adv3;
  assign adv1      = !v1 || adv2;
  assign req_ready = adv1;
  assign rsp_valid = v3;

  awsf_exec u_exec (
    .opnd (s1),
    .ex   (ex_next)
  );

  awsf_flags u_flags (
    .ex (s2),
    .fl (fl_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= req_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  // operand register
  always_ff @(posedge clk) begin
    if (adv1 && req_valid) begin
      s1.op    <= opcode;
      s1.bytem <= byte_mode;
      s1.a     <= byte_mode ? (operand_a & awsf_pkg::MASK8) : operand_a;
      s1.b     <= byte_mode ? (operand_b & awsf_pkg::MASK8) : operand_b;
      s1.cnt   <= shift_count;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1) s2 <= ex_next;
  end

  always_ff @(posedge clk) begin
    if (adv3 && v2) begin
      result        <= s2.res;
      carry_flag    <= s2.cf;
      overflow_flag <= s2.of;
      zero_flag     <= fl_next.zf;
      sign_flag     <= fl_next.sf;
      parity_flag   <= fl_next.pf;
      bytem3        <= s2.bytem;
    end
  end

`ifndef SYNTHESIS
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> v1)
    else $error("accepted request missing from stage one");

  a_s2_holds: assert property (@(posedge clk) disable iff (rst)
    v2 && !adv2 |=> v2 && $stable(s2))
    else $error("stalled stage two changed");

  a_byte_upper_zero: assert property (@(posedge clk) disable iff (rst)
    v3 && bytem3 |-> result[15:8] == 8'h00)
    else $error("byte result has nonzero upper byte");

  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    v3 && zero_flag |-> result == 16'h0000 && !sign_flag)
    else $error("zero flag with nonzero result or sign set");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    v1 && v2 && v3 && !rsp_ready |-> !req_ready)
    else $error("request taken into a full pipeline");
`endif

endmodule

[tb/alu_flags_checker.sv]
// alu_flags_checker: watches the request and result channels of alu_with_status_flags,
// predicts result and flags for each request and compares them in order
// depends on awsf_pkg
`timescale 1ns / 1ps

module alu_flags_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_ready,
  input  logic [3:0]  opcode,
  input  logic        byte_mode,
  input  logic [15:0] operand_a,
  input  logic [15:0] operand_b,
  input  logic [4:0]  shift_count,
  input  logic        rsp_valid,
  input  logic        rsp_ready,
  input  logic [15:0] result,
  input  logic        carry_flag,
  input  logic        overflow_flag,
  input  logic        zero_flag,
  input  logic        sign_flag,
  input  logic        parity_flag,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [15:0] result;
    logic        carry;
    logic        overflow;
    logic        zero;
    logic        sign;
    logic        parity;
  } alu_outcome_t;

  alu_outcome_t outcomes_due[$];

  function automatic alu_outcome_t predict_outcome(
    input logic [3:0]  op,
    input logic        bytem,
    input logic [15:0] a_in,
    input logic [15:0] b_in,
    input logic [4:0]  cnt
  );
    alu_outcome_t o;
    logic [63:0]  mask;
    logic [63:0]  a;
    logic [63:0]  b;
    logic [63:0]  sum;
    logic [63:0]  ext;
    logic [63:0]  fill;
    logic [63:0]  shifted;
    logic [63:0]  res;
    int           msb;
    logic         sa;
    logic         sb;
    logic         cf;
    logic         of;
    logic         known;
    mask  = bytem ? 64'hFF : 64'hFFFF;
    msb   = bytem ? 7 : 15;
    a     = {48'd0, a_in} & mask;
    b     = {48'd0, b_in} & mask;
    sa    = a[msb];
    sb    = b[msb];
    res   = '0;
    cf    = 1'b0;
    of    = 1'b0;
    known = 1'b1;
    case (op)
      awsf_pkg::OP_ADD: begin
        sum = a + b;
        res = sum & mask;
        cf  = sum[msb+1];
        of  = (sa == sb) && (res[msb] != sa);
      end
      awsf_pkg::OP_SUB: begin
        res = (a - b) & mask;
        cf  = a < b;
        of  = (sa != sb) && (res[msb] != sa);
      end
      awsf_pkg::OP_AND: res = a & b;
      awsf_pkg::OP_OR:  res = a | b;
      awsf_pkg::OP_XOR: res = a ^ b;
      awsf_pkg::OP_NEG: begin
        res = (64'd0 - a) & mask;
        cf  = a != 0;
      end
      awsf_pkg::OP_SHL: begin
        res = (a << cnt) & mask;
        if (cnt != 0) begin
          shifted = a << (cnt - 1);
          cf = shifted[msb];
        end
        of = res[msb] != cf;
      end
      awsf_pkg::OP_SHR: begin
        res = (a >> cnt) & mask;
        if (cnt != 0) begin
          shifted = a >> (cnt - 1);
          cf = shifted[0];
        end
        of = res[msb];
      end
      awsf_pkg::OP_SAR: begin
        // sign-extend past the operand width so the fill follows the sign bit
        ext  = sa ? (a | ~mask) : a;
        fill = sa ? ~({64{1'b1}} >> cnt) : '0;
        res  = ((ext >> cnt) | fill) & mask;
        if (cnt != 0) begin
          shifted = ext >> (cnt - 1);
          cf = shifted[0];
        end
        of = res[msb];
      end
      default: known = 1'b0;
    endcase
    o.result   = res[15:0];
    o.carry    = cf;
    o.overflow = of;
    o.zero     = known && (res == 0);
    o.sign     = known && res[msb];
    o.parity   = known && ~^res[7:0];
    return o;
  endfunction

  task automatic check_field(input string name, input logic [15:0] exp, input logic [15:0] act);
    if (exp !== act) begin
      $error("%s: expected %h, actual %h", name, exp, act);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    alu_outcome_t due;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (outcomes_due.size() == 0) begin
          $error("result: expected none, actual %h", result);
          fail_count++;
        end else begin
          due = outcomes_due.pop_front();
          check_field("result", due.result, result);
          check_field("carry_flag", 16'(due.carry), 16'(carry_flag));
          check_field("overflow_flag", 16'(due.overflow), 16'(overflow_flag));
          check_field("zero_flag", 16'(due.zero), 16'(zero_flag));
          check_field("sign_flag", 16'(due.sign), 16'(sign_flag));
          check_field("parity_flag", 16'(due.parity), 16'(parity_flag));
        end
      end
      if (req_valid && req_ready)
        outcomes_due.push_back(
          predict_outcome(opcode, byte_mode, operand_a, operand_b, shift_count));
    end
    pending = outcomes_due.size();
  end

endmodule

[tb/tb_top.sv]
// tb_top: drives directed and random requests into alu_with_status_flags with random
// gaps and result stalls, and reports the verdict from alu_flags_checker
// depends on awsf_pkg, alu_with_status_flags and alu_flags_checker
`timescale 1ns / 1ps

module tb_top;

  localparam logic [3:0] OP_UNUSED_LO = 4'd9;
  localparam logic [3:0] OP_UNUSED_HI = 4'd15;
  localparam int         RANDOM_REQUESTS = 450;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_ready;
  logic [3:0]  opcode;
  logic        byte_mode;
  logic [15:0] operand_a;
  logic [15:0] operand_b;
  logic [4:0]  shift_count;
  logic        rsp_valid;
  logic        rsp_ready;
  logic [15:0] result;
  logic        carry_flag;
  logic        overflow_flag;
  logic        zero_flag;
  logic        sign_flag;
  logic        parity_flag;
  int          fail_count;
  int          pending;
  logic        req_calm;

  alu_with_status_flags dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready),
    .opcode(opcode), .byte_mode(byte_mode),
    .operand_a(operand_a), .operand_b(operand_b), .shift_count(shift_count),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
    .result(result), .carry_flag(carry_flag), .overflow_flag(overflow_flag),
    .zero_flag(zero_flag), .sign_flag(sign_flag), .parity_flag(parity_flag)
  );

  alu_flags_checker u_checker (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready),
    .opcode(opcode), .byte_mode(byte_mode),
    .operand_a(operand_a), .operand_b(operand_b), .shift_count(shift_count),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
    .result(result), .carry_flag(carry_flag), .overflow_flag(overflow_flag),
    .zero_flag(zero_flag), .sign_flag(sign_flag), .parity_flag(parity_flag),
    .fail_count(fail_count), .pending(pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // mostly short idle stretches, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic logic [15:0] pick_operand();
    logic [15:0] corners[8];
    corners = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h00FF, 16'h0080, 16'h007F, 16'h0001};
    if ($urandom_range(0, 4) == 0) return corners[$urandom_range(0, 7)];
    return 16'($urandom);
  endfunction

  // caller stands at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(input logic [3:0] op, input logic bytem,
                              input logic [15:0] a, input logic [15:0] b,
                              input logic [4:0] cnt);
    int gap;
    gap = req_calm ? 0 : idle_len();
    if (gap > 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid   = 1'b1;
    opcode      = op;
    byte_mode   = bytem;
    operand_a   = a;
    operand_b   = b;
    shift_count = cnt;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // result side backpressure
  initial begin
    logic calm;
    calm = 1'b0;
    rsp_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) calm = !calm;
      rsp_ready = 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      if (!calm) begin
        rsp_ready = 1'b0;
        repeat (idle_len()) @(negedge clk);
      end
    end
  end

  initial begin
    #2ms;
    $display("alu_with_status_flags: mismatch");
    $finish;
  end

  initial begin
    logic [3:0] op;
    logic [4:0] cnt;
    rst         = 1'b1;
    req_valid   = 1'b0;
    req_calm    = 1'b0;
    opcode      = awsf_pkg::OP_ADD;
    byte_mode   = 1'b0;
    operand_a   = '0;
    operand_b   = '0;
    shift_count = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // carry, overflow and width corners
    send_request(awsf_pkg::OP_ADD, 1'b0, 16'hFFFF, 16'h0001, 5'd0);
    send_request(awsf_pkg::OP_ADD, 1'b0, 16'h7FFF, 16'h0001, 5'd0);
    send_request(awsf_pkg::OP_ADD, 1'b1, 16'hAB80, 16'h1280, 5'd0);
    send_request(awsf_pkg::OP_SUB, 1'b0, 16'h0000, 16'h0001, 5'd0);
    send_request(awsf_pkg::OP_SUB, 1'b0, 16'h8000, 16'h0001, 5'd0);
    send_request(awsf_pkg::OP_SUB, 1'b1, 16'hFF7F, 16'h00FF, 5'd0);
    send_request(awsf_pkg::OP_AND, 1'b0, 16'hFFFF, 16'hA5A5, 5'd0);
    send_request(awsf_pkg::OP_OR,  1'b1, 16'hF000, 16'h0F00, 5'd0);
    send_request(awsf_pkg::OP_XOR, 1'b0, 16'hFFFF, 16'hFFFF, 5'd0);
    send_request(awsf_pkg::OP_NEG, 1'b0, 16'h0000, 16'h0000, 5'd0);
    send_request(awsf_pkg::OP_NEG, 1'b0, 16'h8000, 16'h0000, 5'd0);
    send_request(awsf_pkg::OP_NEG, 1'b1, 16'h1280, 16'h0000, 5'd0);
    // shifts: zero count, at width, beyond width; then unused opcodes
    send_request(awsf_pkg::OP_SHL, 1'b0, 16'hC001, 16'h0000, 5'd0);
    send_request(awsf_pkg::OP_SHL, 1'b0, 16'h8000, 16'h0000, 5'd1);
    send_request(awsf_pkg::OP_SHL, 1'b0, 16'h0001, 16'h0000, 5'd16);
    send_request(awsf_pkg::OP_SHL, 1'b1, 16'hFF81, 16'h0000, 5'd31);
    send_request(awsf_pkg::OP_SHR, 1'b0, 16'h8001, 16'h0000, 5'd0);
    send_request(awsf_pkg::OP_SHR, 1'b0, 16'h8000, 16'h0000, 5'd15);
    send_request(awsf_pkg::OP_SHR, 1'b1, 16'hFFFF, 16'h0000, 5'd8);
    send_request(awsf_pkg::OP_SAR, 1'b0, 16'h8000, 16'h0000, 5'd3);
    send_request(awsf_pkg::OP_SAR, 1'b1, 16'h0080, 16'h0000, 5'd8);
    send_request(awsf_pkg::OP_SAR, 1'b0, 16'hFFFF, 16'h0000, 5'd31);
    send_request(awsf_pkg::OP_SAR, 1'b1, 16'h5580, 16'h0000, 5'd0);
    send_request(OP_UNUSED_LO, 1'b0, 16'h1234, 16'h5678, 5'd3);
    send_request(OP_UNUSED_HI, 1'b1, 16'hFFFF, 16'hFFFF, 5'd31);

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i % 40 == 0) req_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) op = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      else op = 4'($urandom_range(awsf_pkg::OP_ADD, awsf_pkg::OP_SAR));
      if ($urandom_range(0, 3) == 0) cnt = 5'($urandom);
      else cnt = 5'($urandom_range(0, 17));
      send_request(op, 1'($urandom_range(0, 1)), pick_operand(), pick_operand(), cnt);
    end
    req_valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("alu_with_status_flags: match");
    end else begin
      $display("alu_with_status_flags: mismatch");
    end
    $finish;
  end

endmodule
